// File: rtl/ngga_pkg.sv
// ----------------------------------------------------------------------------
// ngga_pkg
// Shared constants, types and tables of the GGA position parser.
// ----------------------------------------------------------------------------
package ngga_pkg;

    localparam int FRACTION_DIGITS_DEF = 5;
    localparam int FIELD_CHARS_DEF     = 14;
    localparam int INDEX_BITS_DEF      = 16;

    localparam int BYTE_W     = 8;
    localparam int FIXED_W    = 32;
    localparam int FIX_IDX_W  = 16;
    localparam int FRAC_CNT_W = 3;
    localparam int CHAR_CNT_W = 4;
    localparam int POW10_W    = 24;
    localparam int HDR_IDX_W  = 3;
    localparam int OUT_DATA_W = 2 * FIXED_W + FIX_IDX_W;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    localparam logic [FIXED_W-1:0] SAT_VALUE = '1;

    // Control from the sentence sequencer to the field converter.
    typedef struct packed {
        logic feed;
        logic clear;
    } field_ctrl_t;

    // Expected header character "$GPGGA," at each match position.
    function automatic logic [BYTE_W-1:0] header_char(input logic [HDR_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = CH_G;
            3'd2:    c = CH_P;
            3'd3:    c = CH_G;
            3'd4:    c = CH_G;
            3'd5:    c = CH_A;
            3'd6:    c = CH_COMMA;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    function automatic logic [POW10_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
        logic [POW10_W-1:0] p;
        case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/ngga_field.sv
// ----------------------------------------------------------------------------
// ngga_field
// Decimal field converter: accumulates digits with one optional point and
// scales the result to a fixed number of fraction places, saturating.
// ----------------------------------------------------------------------------
module ngga_field #(
    parameter int FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF,
    parameter int FIELD_CHARS     = ngga_pkg::FIELD_CHARS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ngga_pkg::field_ctrl_t            ctrl,
    input  logic [ngga_pkg::BYTE_W-1:0]      rx_byte,
    output logic [ngga_pkg::FIXED_W-1:0]     value
);

    localparam logic [ngga_pkg::FRAC_CNT_W-1:0] FRAC_MAX =
        ngga_pkg::FRAC_CNT_W'(FRACTION_DIGITS);
    localparam logic [ngga_pkg::CHAR_CNT_W-1:0] CHAR_MAX =
        ngga_pkg::CHAR_CNT_W'(FIELD_CHARS);
    localparam int MUL_W = ngga_pkg::FIXED_W + 4;
    localparam int PROD_W = ngga_pkg::FIXED_W + ngga_pkg::POW10_W;

    logic [ngga_pkg::FIXED_W-1:0]    acc_reg, acc_next;
    logic [ngga_pkg::FRAC_CNT_W-1:0] frac_cnt_reg, frac_cnt_next;
    logic                            point_reg, point_next;
    logic                            stop_reg, stop_next;
    logic [ngga_pkg::CHAR_CNT_W-1:0] char_cnt_reg, char_cnt_next;

    logic                            is_digit;
    logic [MUL_W-1:0]                mac;
    logic [ngga_pkg::FIXED_W-1:0]    mac_sat;
    logic [PROD_W-1:0]               scaled;

    assign is_digit = (rx_byte >= ngga_pkg::CH_ZERO) && (rx_byte <= ngga_pkg::CH_NINE);
    assign mac = MUL_W'(acc_reg) * MUL_W'(10) + MUL_W'(rx_byte - ngga_pkg::CH_ZERO);
    assign mac_sat = (mac[MUL_W-1:ngga_pkg::FIXED_W] != '0) ? ngga_pkg::SAT_VALUE
                                                             : mac[ngga_pkg::FIXED_W-1:0];

    // Scaling by ten once per missing fraction place saturates exactly like
    // one product with the matching power of ten.
    assign scaled = PROD_W'(acc_reg) * PROD_W'(ngga_pkg::pow10(FRAC_MAX - frac_cnt_reg));
    assign value = (scaled[PROD_W-1:ngga_pkg::FIXED_W] != '0) ? ngga_pkg::SAT_VALUE
                                                               : scaled[ngga_pkg::FIXED_W-1:0];

    always_comb begin
        acc_next      = acc_reg;
        frac_cnt_next = frac_cnt_reg;
        point_next    = point_reg;
        stop_next     = stop_reg;
        char_cnt_next = char_cnt_reg;
        if (ctrl.clear) begin
            acc_next      = '0;
            frac_cnt_next = '0;
            point_next    = 1'b0;
            stop_next     = 1'b0;
            char_cnt_next = '0;
        end else if (ctrl.feed && (char_cnt_reg < CHAR_MAX)) begin
            char_cnt_next = char_cnt_reg + 1'b1;
            if (!stop_reg) begin
                if (is_digit) begin
                    if (!point_reg) begin
                        acc_next = mac_sat;
                    end else if (frac_cnt_reg < FRAC_MAX) begin
                        acc_next      = mac_sat;
                        frac_cnt_next = frac_cnt_reg + 1'b1;
                    end
                end else if ((rx_byte == ngga_pkg::CH_POINT) && !point_reg) begin
                    point_next = 1'b1;
                end else begin
                    stop_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            frac_cnt_reg <= '0;
            point_reg    <= 1'b0;
            stop_reg     <= 1'b0;
            char_cnt_reg <= '0;
        end else begin
            acc_reg      <= acc_next;
            frac_cnt_reg <= frac_cnt_next;
            point_reg    <= point_next;
            stop_reg     <= stop_next;
            char_cnt_reg <= char_cnt_next;
        end
    end

endmodule

// File: rtl/nmea_gga_position_parser_top.sv
// ----------------------------------------------------------------------------
// nmea_gga_position_parser_top
// Parses GGA sentences from a byte stream into fixed-point positions.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one received character per item. The block looks
//   for the header "$GPGGA,", skips the time field, converts the latitude
//   field, skips the hemisphere field and converts the longitude field.
//   At the comma that closes the longitude field one item leaves on the
//   master channel with both values (field value times 10^FRACTION_DIGITS,
//   saturating) and a wrapping sentence index.
//   Throughput: one character per cycle while no untaken result blocks it.
//   Each character only needs a phase update and one multiply-by-ten
//   accumulate; a closing comma adds a power-of-ten multiply of field registers.
//   Latency: the result is valid in the cycle after the closing comma is
//   accepted. The master side has a single output register; while it holds
//   an item the receiver has not taken, s_axis_tready drops only if
//   m_axis_tready is low, so no result is lost.
//   Reset (aresetn low, synchronous) returns the parser to the header hunt,
//   clears the field converter, the held latitude and the sentence index,
//   and empties the output register.
// ----------------------------------------------------------------------------
module nmea_gga_position_parser_top #(
    parameter int FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF,
    parameter int FIELD_CHARS     = ngga_pkg::FIELD_CHARS_DEF,
    parameter int INDEX_BITS      = ngga_pkg::INDEX_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] rx_byte
    input  logic [ngga_pkg::BYTE_W-1:0]         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] latitude_fixed, [63:32] longitude_fixed, [79:64] fix_index
    output logic [ngga_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam logic [3:0] PH_HUNT      = 4'd0;
    localparam logic [3:0] PH_SKIP_TIME = 4'd7;
    localparam logic [3:0] PH_LAT       = 4'd8;
    localparam logic [3:0] PH_SKIP_HEMI = 4'd9;
    localparam logic [3:0] PH_LON       = 4'd10;

    logic [3:0]                          phase_reg, phase_next;
    logic [ngga_pkg::FIXED_W-1:0]        lat_hold_reg, lat_hold_next;
    logic [INDEX_BITS-1:0]               fix_cnt_reg, fix_cnt_next;
    logic                                m_valid_reg;
    logic [ngga_pkg::OUT_DATA_W-1:0]     m_data_reg;

    logic                                accept;
    logic                                emit;
    logic                                is_comma;
    logic [ngga_pkg::FIXED_W-1:0]        field_value;
    logic [31:0]                         fix_wide;
    ngga_pkg::field_ctrl_t               fctrl;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_comma      = (s_axis_tdata == ngga_pkg::CH_COMMA);
    assign fix_wide      = 32'(fix_cnt_reg);

    ngga_field #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .FIELD_CHARS     (FIELD_CHARS)
    ) u_field (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fctrl),
        .rx_byte (s_axis_tdata),
        .value   (field_value)
    );

    always_comb begin
        phase_next    = phase_reg;
        lat_hold_next = lat_hold_reg;
        fix_cnt_next  = fix_cnt_reg;
        emit          = 1'b0;
        fctrl         = '0;
        if (accept) begin
            if (phase_reg < PH_SKIP_TIME) begin
                // A mismatching byte is consumed; the hunt restarts after it.
                if (s_axis_tdata == ngga_pkg::header_char(phase_reg[ngga_pkg::HDR_IDX_W-1:0]))
                begin
                    phase_next = phase_reg + 1'b1;
                end else begin
                    phase_next = PH_HUNT;
                end
            end else begin
                case (phase_reg)
                    PH_SKIP_TIME, PH_SKIP_HEMI: begin
                        if (is_comma) begin
                            phase_next  = phase_reg + 1'b1;
                            fctrl.clear = 1'b1;
                        end
                    end
                    PH_LAT: begin
                        if (is_comma) begin
                            lat_hold_next = field_value;
                            phase_next    = PH_SKIP_HEMI;
                            fctrl.clear   = 1'b1;
                        end else begin
                            fctrl.feed = 1'b1;
                        end
                    end
                    PH_LON: begin
                        if (is_comma) begin
                            emit         = 1'b1;
                            fix_cnt_next = fix_cnt_reg + 1'b1;
                            phase_next   = PH_HUNT;
                            fctrl.clear  = 1'b1;
                        end else begin
                            fctrl.feed = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            lat_hold_reg <= '0;
            fix_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            lat_hold_reg <= lat_hold_next;
            fix_cnt_reg  <= fix_cnt_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= {fix_wide[ngga_pkg::FIX_IDX_W-1:0], field_value, lat_hold_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A result always carries the index held before it and advances it by one.
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (fix_cnt_reg == $past(fix_cnt_reg) + 1'b1) && m_axis_tvalid
             && (m_axis_tdata[ngga_pkg::OUT_DATA_W-1:2*ngga_pkg::FIXED_W]
                 == $past(fix_wide[ngga_pkg::FIX_IDX_W-1:0])))
        else $error("sentence index did not advance with the result");

    // Input stalls only behind an unaccepted result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a waiting result");

    // After a result the parser is back to hunting for a header.
    a_hunt_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (phase_reg == PH_HUNT))
        else $error("parser not hunting after a result");

    // The held latitude only changes at the comma that closes that field.
    a_lat_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && (phase_reg == PH_LAT) && is_comma) |=> $stable(lat_hold_reg))
        else $error("latitude changed outside its closing comma");

endmodule

// File: sim/nmea_gga_position_parser_top_tb.sv
// ----------------------------------------------------------------------------
// nmea_gga_position_parser_top_tb
// Self-checking bench for the GGA position parser. A short table of
// sentences covers the header hunt, conversion stops, fraction truncation,
// saturation and long fields. Random sentences and line noise follow,
// driven through phases of sender gaps and receiver stalls. Every result is
// compared field by field with typed values or a parser model in the bench.
// ----------------------------------------------------------------------------
module nmea_gga_position_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_PLACES    = ngga_pkg::FRACTION_DIGITS_DEF;
    localparam int MAX_FIELD_LEN  = ngga_pkg::FIELD_CHARS_DEF;
    localparam int RAND_ITEMS     = 750;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;

    // Parser phases beyond the seven header positions.
    localparam int PH_SKIP_TIME = 7;
    localparam int PH_LAT       = 8;
    localparam int PH_SKIP_HEMI = 9;
    localparam int PH_LON       = 10;

    localparam logic [55:0] HDR_TEXT   = "$GPGGA,";
    localparam string       STOP_CHARS = " -+$*N";

    typedef struct packed {
        logic [ngga_pkg::FIX_IDX_W-1:0] idx;
        logic [ngga_pkg::FIXED_W-1:0]   lon;
        logic [ngga_pkg::FIXED_W-1:0]   lat;
    } fix_t;

    localparam int N_DIR = 14;
    string dir_text [N_DIR] = '{
        "$GPGGA,,,,,",
        "$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n",
        "$GPGGA,,42949.67294,,42949.67296,",
        "$GPGGA,,50000,,99999999999999,",
        "$GP$GPGGA,,1,,2,$GPGGA,,1,,2,",
        "$$GPGGA,,,,,$GPGGB,$GPGGA,$,,,3.,",
        "$GPGGA,1,12.3.4,N,-5,",
        "$GPGGA,,1 2,S,+7.5,",
        "$GPGGA,,1.1234567,,1.5,",
        "$GPGGA,,000000000000007,,0000000000000.7,",
        "$GPGGA,,1.5,W,25,",
        "$GPGGA,,$1,,.\377,",
        "$GPGGA,,.12345,,99999.,",
        "$GPGGA,,.,,0.00000,"
    };
    bit dir_typed [N_DIR] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    fix_t dir_fix [N_DIR] = '{
        {16'd0, 32'd0,         32'd0},
        {16'd1, 32'd113100000, 32'd480703800},
        {16'd2, 32'hFFFFFFFF,  32'hFFFFFFFE},
        {16'd3, 32'hFFFFFFFF,  32'hFFFFFFFF},
        '0, '0, '0, '0, '0, '0, '0, '0, '0, '0
    };

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ngga_pkg::BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ngga_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Parser model state.
    int                             parse_at   = 0;
    logic [ngga_pkg::FIXED_W-1:0]   conv_acc   = '0;
    int                             conv_frac  = 0;
    bit                             conv_point = 1'b0;
    bit                             conv_stop  = 1'b0;
    int                             conv_chars = 0;
    logic [ngga_pkg::FIXED_W-1:0]   lat_hold   = '0;
    logic [ngga_pkg::FIX_IDX_W-1:0] fix_count  = '0;

    fix_t pending_fixes [$];
    fix_t typed_fixes [$];
    logic [ngga_pkg::BYTE_W-1:0] line_buf [$];

    int errors        = 0;
    int results_seen  = 0;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    bit hold_trigger  = 1'b0;
    bit hold_ack      = 1'b0;

    nmea_gga_position_parser_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [ngga_pkg::BYTE_W-1:0] hdr_char(input int pos);
        return HDR_TEXT[8*(6-pos) +: 8];
    endfunction

    function automatic logic [ngga_pkg::FIXED_W-1:0] mul10_add(
        input logic [ngga_pkg::FIXED_W-1:0] v,
        input logic [3:0] d
    );
        logic [35:0] r;
        r = 36'(v) * 36'd10 + 36'(d);
        return (r > 36'hFFFFFFFF) ? ngga_pkg::SAT_VALUE : r[ngga_pkg::FIXED_W-1:0];
    endfunction

    // Scale the accumulated digits up to the full number of fraction places.
    function automatic logic [ngga_pkg::FIXED_W-1:0] field_value();
        logic [ngga_pkg::FIXED_W-1:0] v;
        v = conv_acc;
        for (int k = conv_frac; k < FRAC_PLACES; k++)
            v = mul10_add(v, 4'd0);
        return v;
    endfunction

    task automatic clear_conv();
        conv_acc   = '0;
        conv_frac  = 0;
        conv_point = 1'b0;
        conv_stop  = 1'b0;
        conv_chars = 0;
    endtask

    task automatic convert_char(input logic [ngga_pkg::BYTE_W-1:0] b);
        if (conv_chars >= MAX_FIELD_LEN)
            return;
        conv_chars++;
        if (conv_stop)
            return;
        if (b >= ngga_pkg::CH_ZERO && b <= ngga_pkg::CH_NINE) begin
            if (!conv_point) begin
                conv_acc = mul10_add(conv_acc, 4'(b - ngga_pkg::CH_ZERO));
            end else if (conv_frac < FRAC_PLACES) begin
                conv_acc = mul10_add(conv_acc, 4'(b - ngga_pkg::CH_ZERO));
                conv_frac++;
            end
        end else if (b == ngga_pkg::CH_POINT && !conv_point) begin
            conv_point = 1'b1;
        end else begin
            conv_stop = 1'b1;
        end
    endtask

    task automatic parse_rx_byte(input logic [ngga_pkg::BYTE_W-1:0] b);
        fix_t fix;
        if (parse_at < PH_SKIP_TIME) begin
            // A byte that breaks the header is consumed, not retried as '$'.
            parse_at = (b == hdr_char(parse_at)) ? parse_at + 1 : 0;
        end else if (parse_at == PH_SKIP_TIME || parse_at == PH_SKIP_HEMI) begin
            if (b == ngga_pkg::CH_COMMA) begin
                parse_at++;
                clear_conv();
            end
        end else if (parse_at == PH_LAT || parse_at == PH_LON) begin
            if (b != ngga_pkg::CH_COMMA) begin
                convert_char(b);
            end else if (parse_at == PH_LAT) begin
                lat_hold = field_value();
                parse_at = PH_SKIP_HEMI;
                clear_conv();
            end else begin
                fix.lat = lat_hold;
                fix.lon = field_value();
                fix.idx = fix_count;
                fix_count++;
                parse_at = 0;
                clear_conv();
                if (typed_fixes.size() != 0)
                    pending_fixes.push_back(typed_fixes.pop_front());
                else
                    pending_fixes.push_back(fix);
            end
        end else begin
            parse_at = 0;
        end
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_fix(input fix_t got);
        fix_t want;
        results_seen++;
        if (pending_fixes.size() == 0) begin
            note_error($sformatf("unexpected result %h", got));
            return;
        end
        want = pending_fixes.pop_front();
        if (got.lat != want.lat)
            note_error($sformatf("latitude expected %h, got %h", want.lat, got.lat));
        if (got.lon != want.lon)
            note_error($sformatf("longitude expected %h, got %h", want.lon, got.lon));
        if (got.idx != want.idx)
            note_error($sformatf("fix index expected %h, got %h", want.idx, got.idx));
    endtask

    // Results are checked before the same edge's input byte is modeled, since
    // a result can leave no earlier than the cycle after its closing comma.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                check_fix(fix_t'(m_axis_tdata));
            if (s_axis_tvalid && s_axis_tready)
                parse_rx_byte(s_axis_tdata);
        end
    end

    always @(posedge aclk) begin
        if (hold_trigger != hold_ack) begin
            hold_ack      <= hold_trigger;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input logic [ngga_pkg::BYTE_W-1:0] b);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_all_fixes();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_fixes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic add_digits(input int n);
        repeat (n) line_buf.push_back(ngga_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic add_any(input int n);
        logic [ngga_pkg::BYTE_W-1:0] b;
        repeat (n) begin
            do b = 8'($urandom_range(255)); while (b == ngga_pkg::CH_COMMA);
            line_buf.push_back(b);
        end
    endtask

    task automatic add_number_field();
        int kind;
        int pick;
        kind = $urandom_range(9);
        case (kind)
            0: ;
            1, 2, 3, 4, 5: begin
                add_digits($urandom_range(1, 5));
                if ($urandom_range(4) != 0) begin
                    line_buf.push_back(ngga_pkg::CH_POINT);
                    add_digits($urandom_range(0, 8));
                end
            end
            6: add_digits($urandom_range(8, 18));
            7: add_any($urandom_range(1, 16));
            default: begin
                repeat ($urandom_range(1, 10)) begin
                    pick = $urandom_range(5);
                    if (pick <= 2)
                        add_digits(1);
                    else if (pick == 3)
                        line_buf.push_back(ngga_pkg::CH_POINT);
                    else if (pick == 4)
                        line_buf.push_back(STOP_CHARS[$urandom_range(STOP_CHARS.len() - 1)]);
                    else
                        add_any(1);
                end
            end
        endcase
        line_buf.push_back(ngga_pkg::CH_COMMA);
    endtask

    task automatic build_sentence();
        int bad_pos;
        logic [ngga_pkg::BYTE_W-1:0] c;
        bad_pos = ($urandom_range(9) == 0) ? $urandom_range(6) : -1;
        for (int i = 0; i < 7; i++) begin
            c = (i == bad_pos) ? 8'($urandom_range(255)) : hdr_char(i);
            line_buf.push_back(c);
        end
        if ($urandom_range(3) == 0)
            add_any($urandom_range(0, 4));
        else
            add_digits($urandom_range(0, 10));
        line_buf.push_back(ngga_pkg::CH_COMMA);
        add_number_field();
        add_any($urandom_range(0, 2));
        line_buf.push_back(ngga_pkg::CH_COMMA);
        add_number_field();
        if ($urandom_range(1) == 0)
            add_any($urandom_range(0, 6));
    endtask

    initial begin
        string row;
        int    rnd_bytes;
        int    phase;
        int    next_phase;
        bit    counted;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Byte extremes while hunting for the header.
        send_byte(8'h00);
        send_byte(8'hFF);

        for (int r = 0; r < N_DIR; r++) begin
            row = dir_text[r];
            for (int i = 0; i < row.len(); i++) begin
                send_byte(row[i]);
                // Queued after the leading '$', which can never close a sentence.
                if (i == 0 && dir_typed[r])
                    typed_fixes.push_back(dir_fix[r]);
            end
        end

        rnd_bytes = 0;
        phase     = -1;
        while (rnd_bytes < RAND_ITEMS) begin
            next_phase = rnd_bytes * 4 / RAND_ITEMS;
            if (next_phase > 3)
                next_phase = 3;
            if (next_phase != phase) begin
                phase = next_phase;
                wait_all_fixes();
                case (phase)
                    0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                    1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
                    2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
                    default: begin src_idle_pct = 21; sink_stall_pct = 21; end
                endcase
                // A long receiver hold while bytes keep coming fills the output.
                if (phase >= 2)
                    hold_trigger <= ~hold_trigger;
            end
            line_buf.delete();
            counted = ($urandom_range(99) >= 15);
            if (counted) begin
                build_sentence();
            end else begin
                repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
            end
            foreach (line_buf[i])
                send_byte(line_buf[i]);
            if (counted)
                rnd_bytes += line_buf.size();
        end

        wait_all_fixes();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_fixes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
